// ----- design/tpid_pkg.sv -----
package tpid_pkg;

    localparam int RATE_WIDTH  = 16;
    localparam int NUM_AXES    = 3;
    localparam int GAIN_W      = 16;
    localparam int STEP_W      = 16;
    localparam int DT_W        = 15;
    localparam int ERR_W       = RATE_WIDTH + 1;
    localparam int DE_W        = RATE_WIDTH + 2;
    localparam int ACC_W       = 32;
    localparam int EPROD_W     = ERR_W + DT_W;
    localparam int ACC_SUM_W   = ((ACC_W > EPROD_W) ? ACC_W : EPROD_W) + 1;
    localparam int PPROD_W     = GAIN_W + ERR_W;
    localparam int IPROD_W     = GAIN_W + ACC_W;
    localparam int DPROD_W     = GAIN_W + DE_W;
    localparam int DMAG_W      = DPROD_W - 1;
    localparam int P_SHIFT     = 9;
    localparam int I_SHIFT     = 29;
    localparam int D_SHIFT     = 11;
    localparam int NUM_W       = DMAG_W + D_SHIFT;
    localparam int CNT_W       = $clog2(NUM_W);
    localparam int SUM_W       = NUM_W + 2;
    localparam int DRIVE_W     = 16;
    localparam int LIMIT_W     = 15;
    localparam int ACC_LIMIT_W = 31;
    localparam int DATA_W      = 64;
    localparam int ADDR_W      = 6;
    localparam int IDX_LSB     = 3;
    localparam int IDX_W       = ADDR_W - IDX_LSB;

    localparam int AX_ROLL  = 0;
    localparam int AX_PITCH = 1;
    localparam int AX_YAW   = 2;

    localparam logic [STEP_W-1:0] STEP_MIN_US = STEP_W'(500);
    localparam logic [STEP_W-1:0] STEP_MAX_US = STEP_W'(20000);
    localparam logic [CNT_W-1:0]  DIV_LAST    = CNT_W'(NUM_W - 1);

    localparam logic [3*GAIN_W-1:0]    ROLL_GAINS_RESET  = (3*GAIN_W)'(2097);
    localparam logic [3*GAIN_W-1:0]    PITCH_GAINS_RESET = (3*GAIN_W)'(2097);
    localparam logic [3*GAIN_W-1:0]    YAW_GAINS_RESET   = (3*GAIN_W)'(1049);
    localparam logic [LIMIT_W-1:0]     CMD_LIMIT_RESET   = LIMIT_W'(11469);
    localparam logic [ACC_LIMIT_W-1:0] ACC_LIMIT_RESET   = ACC_LIMIT_W'(3200000);

    typedef enum logic [IDX_W-1:0] {
        REG_ROLL_GAINS        = 3'd0,
        REG_PITCH_GAINS       = 3'd1,
        REG_YAW_GAINS         = 3'd2,
        REG_COMMAND_LIMIT     = 3'd3,
        REG_ACCUMULATOR_LIMIT = 3'd4
    } reg_index_t;

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } ctl_state_t;

    typedef enum logic [2:0] {
        LN_IDLE,
        LN_MUL,
        LN_ACC,
        LN_DIV,
        LN_SUM,
        LN_CLAMP
    } lane_state_t;

    typedef struct packed {
        logic [GAIN_W-1:0] kd;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kp;
    } gain_set_t;

    typedef struct packed {
        gain_set_t [NUM_AXES-1:0]  gains;
        logic [LIMIT_W-1:0]        command_limit;
        logic [ACC_LIMIT_W-1:0]    accumulator_limit;
    } cfg_t;

    typedef struct packed {
        logic                   start;
        logic                   clear;
        logic [DT_W-1:0]        dt;
        logic [RATE_WIDTH-1:0]  want;
        logic [RATE_WIDTH-1:0]  gyro;
        gain_set_t              gains;
        logic [LIMIT_W-1:0]     command_limit;
        logic [ACC_LIMIT_W-1:0] accumulator_limit;
    } lane_req_t;

    typedef struct packed {
        logic               done;
        logic [DRIVE_W-1:0] drive;
    } lane_rsp_t;

endpackage

// ----- design/tpid_if.sv -----
interface tpid_in_if import tpid_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  command;
    logic [STEP_W-1:0]     step_us;
    logic [RATE_WIDTH-1:0] want_roll;
    logic [RATE_WIDTH-1:0] want_pitch;
    logic [RATE_WIDTH-1:0] want_yaw;
    logic [RATE_WIDTH-1:0] gyro_roll;
    logic [RATE_WIDTH-1:0] gyro_pitch;
    logic [RATE_WIDTH-1:0] gyro_yaw;

    modport source (
        output valid, command, step_us, want_roll, want_pitch, want_yaw,
               gyro_roll, gyro_pitch, gyro_yaw,
        input  ready
    );

    modport sink (
        input  valid, command, step_us, want_roll, want_pitch, want_yaw,
               gyro_roll, gyro_pitch, gyro_yaw,
        output ready
    );
endinterface

interface tpid_out_if import tpid_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DRIVE_W-1:0] roll_drive;
    logic [DRIVE_W-1:0] pitch_drive;
    logic [DRIVE_W-1:0] yaw_drive;

    modport source (
        output valid, roll_drive, pitch_drive, yaw_drive,
        input  ready
    );

    modport sink (
        input  valid, roll_drive, pitch_drive, yaw_drive,
        output ready
    );
endinterface

// ----- design/tpid_regs.sv -----
module tpid_regs import tpid_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    reg_index_t                idx;
    logic                      wr;
    gain_set_t [NUM_AXES-1:0]  gains_reg, gains_next;
    logic [LIMIT_W-1:0]        cmd_limit_reg, cmd_limit_next;
    logic [ACC_LIMIT_W-1:0]    acc_limit_reg, acc_limit_next;

    assign pready = 1'b1;
    assign idx    = reg_index_t'(paddr[ADDR_W-1:IDX_LSB]);
    assign wr     = psel & penable & pwrite & pready;

    always_comb
    begin
        gains_next     = gains_reg;
        cmd_limit_next = cmd_limit_reg;
        acc_limit_next = acc_limit_reg;
        if (wr)
        begin
            unique case (idx)
                REG_ROLL_GAINS:        gains_next[AX_ROLL]  = pwdata[3*GAIN_W-1:0];
                REG_PITCH_GAINS:       gains_next[AX_PITCH] = pwdata[3*GAIN_W-1:0];
                REG_YAW_GAINS:         gains_next[AX_YAW]   = pwdata[3*GAIN_W-1:0];
                REG_COMMAND_LIMIT:     cmd_limit_next       = pwdata[LIMIT_W-1:0];
                REG_ACCUMULATOR_LIMIT: acc_limit_next       = pwdata[ACC_LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg[AX_ROLL]  <= ROLL_GAINS_RESET;
            gains_reg[AX_PITCH] <= PITCH_GAINS_RESET;
            gains_reg[AX_YAW]   <= YAW_GAINS_RESET;
            cmd_limit_reg       <= CMD_LIMIT_RESET;
            acc_limit_reg       <= ACC_LIMIT_RESET;
        end
        else
        begin
            gains_reg     <= gains_next;
            cmd_limit_reg <= cmd_limit_next;
            acc_limit_reg <= acc_limit_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_ROLL_GAINS:        prdata = DATA_W'(gains_reg[AX_ROLL]);
            REG_PITCH_GAINS:       prdata = DATA_W'(gains_reg[AX_PITCH]);
            REG_YAW_GAINS:         prdata = DATA_W'(gains_reg[AX_YAW]);
            REG_COMMAND_LIMIT:     prdata = DATA_W'(cmd_limit_reg);
            REG_ACCUMULATOR_LIMIT: prdata = DATA_W'(acc_limit_reg);
            default:               prdata = '0;
        endcase
    end

    assign cfg = '{gains: gains_reg, command_limit: cmd_limit_reg,
                   accumulator_limit: acc_limit_reg};

endmodule

// ----- design/tpid_lane.sv -----
module tpid_lane import tpid_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  lane_req_t req,
    output lane_rsp_t rsp
);

    lane_state_t               state_reg, state_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [ERR_W-1:0]   last_reg, last_next;
    logic [DT_W-1:0]           dt_reg, dt_next;
    logic signed [EPROD_W-1:0] eprod_reg, eprod_next;
    logic signed [PPROD_W-1:0] pprod_reg, pprod_next;
    logic signed [DPROD_W-1:0] dprod_reg, dprod_next;
    logic signed [IPROD_W-1:0] iprod_reg, iprod_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [NUM_W-1:0]          num_reg, num_next;
    logic [DT_W-1:0]           rem_reg, rem_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      dneg_reg, dneg_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [DRIVE_W-1:0]        drive_reg, drive_next;
    logic                      done_reg, done_next;

    logic signed [ERR_W-1:0]     err_in;
    logic signed [DE_W-1:0]      de;
    logic signed [ACC_SUM_W-1:0] acc_sum;
    logic signed [ACC_SUM_W-1:0] acc_lim;
    logic [DMAG_W-1:0]           dmag;
    logic [DT_W:0]               rem_sh;
    logic signed [SUM_W-1:0]     pterm;
    logic signed [SUM_W-1:0]     iterm;
    logic signed [SUM_W-1:0]     dterm;
    logic signed [SUM_W-1:0]     out_lim;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            LN_IDLE:  if (req.start && !req.clear) state_next = LN_MUL;
            LN_MUL:   state_next = LN_ACC;
            LN_ACC:   state_next = LN_DIV;
            LN_DIV:   if (cnt_reg == DIV_LAST) state_next = LN_SUM;
            LN_SUM:   state_next = LN_CLAMP;
            LN_CLAMP: state_next = LN_IDLE;
            default:  state_next = LN_IDLE;
        endcase
    end

    always_comb
    begin
        err_in  = ERR_W'($signed(req.want)) - ERR_W'($signed(req.gyro));
        de      = DE_W'(err_reg) - DE_W'(last_reg);
        acc_sum = ACC_SUM_W'(acc_reg) + ACC_SUM_W'(eprod_reg);
        acc_lim = ACC_SUM_W'($signed({1'b0, req.accumulator_limit}));
        dmag    = dprod_reg[DPROD_W-1] ? DMAG_W'(-dprod_reg) : DMAG_W'(dprod_reg);
        rem_sh  = {rem_reg, num_reg[NUM_W-1]};
        pterm   = SUM_W'(pprod_reg >>> P_SHIFT);
        iterm   = SUM_W'(iprod_reg >>> I_SHIFT);
        dterm   = dneg_reg ? -SUM_W'($signed({1'b0, num_reg}))
                           : SUM_W'($signed({1'b0, num_reg}));
        out_lim = SUM_W'($signed({1'b0, req.command_limit}));
    end

    always_comb
    begin
        err_next   = err_reg;
        last_next  = last_reg;
        dt_next    = dt_reg;
        eprod_next = eprod_reg;
        pprod_next = pprod_reg;
        dprod_next = dprod_reg;
        iprod_next = iprod_reg;
        acc_next   = acc_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        dneg_next  = dneg_reg;
        sum_next   = sum_reg;
        drive_next = drive_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            LN_IDLE:
            begin
                if (req.start)
                begin
                    if (req.clear)
                    begin
                        acc_next   = '0;
                        last_next  = '0;
                        drive_next = '0;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        err_next = err_in;
                        dt_next  = req.dt;
                    end
                end
            end
            LN_MUL:
            begin
                eprod_next = EPROD_W'(err_reg) * EPROD_W'($signed({1'b0, dt_reg}));
                pprod_next = PPROD_W'($signed({1'b0, req.gains.kp})) * PPROD_W'(err_reg);
                dprod_next = DPROD_W'($signed({1'b0, req.gains.kd})) * DPROD_W'(de);
                last_next  = err_reg;
            end
            LN_ACC:
            begin
                priority if (acc_sum > acc_lim)
                    acc_next = ACC_W'(acc_lim);
                else if (acc_sum < -acc_lim)
                    acc_next = ACC_W'(-acc_lim);
                else
                    acc_next = ACC_W'(acc_sum);
                num_next  = {dmag, {D_SHIFT{1'b0}}};
                rem_next  = '0;
                cnt_next  = '0;
                dneg_next = dprod_reg[DPROD_W-1];
            end
            LN_DIV:
            begin
                // restoring divide, one quotient bit per cycle
                if (rem_sh >= {1'b0, dt_reg})
                begin
                    rem_next = DT_W'(rem_sh - {1'b0, dt_reg});
                    num_next = {num_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[DT_W-1:0];
                    num_next = {num_reg[NUM_W-2:0], 1'b0};
                end
                cnt_next   = cnt_reg + 1'b1;
                iprod_next = IPROD_W'($signed({1'b0, req.gains.ki})) * IPROD_W'(acc_reg);
            end
            LN_SUM:
            begin
                sum_next = pterm + iterm + dterm;
            end
            LN_CLAMP:
            begin
                priority if (sum_reg > out_lim)
                    drive_next = DRIVE_W'(out_lim);
                else if (sum_reg < -out_lim)
                    drive_next = DRIVE_W'(-out_lim);
                else
                    drive_next = sum_reg[DRIVE_W-1:0];
                done_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LN_IDLE;
            acc_reg   <= '0;
            last_reg  <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            last_reg  <= last_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg   <= err_next;
        dt_reg    <= dt_next;
        eprod_reg <= eprod_next;
        pprod_reg <= pprod_next;
        dprod_reg <= dprod_next;
        iprod_reg <= iprod_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        dneg_reg  <= dneg_next;
        sum_reg   <= sum_next;
        drive_reg <= drive_next;
    end

    assign rsp = '{done: done_reg, drive: drive_reg};

endmodule

// ----- design/three_axis_pid_rate_controller.sv -----
// run word: multiply, accumulate, divide, sum, clamp; no new word until output load
// clear word: lanes zero their state and raise done; no new word until output load
// run time is set by the 44-step restoring divide of the derivative in each lane
// a finished result waits in the output register while the next word is taken
// rst_n is asynchronous, active low: integrators and last errors cleared,
// gain and limit registers back to their defaults
module three_axis_pid_rate_controller import tpid_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    tpid_in_if.sink           req,
    tpid_out_if.source        rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t                              cfg;
    ctl_state_t                        state_reg, state_next;
    logic [NUM_AXES-1:0]               done_bits_reg, done_bits_next;
    logic                              rsp_valid_reg, rsp_valid_next;
    logic [NUM_AXES-1:0][DRIVE_W-1:0]  drive_reg, drive_next;

    logic                              ready_int;
    logic                              accept;
    logic                              all_done;
    logic                              load;
    logic [DT_W-1:0]                   dt_clamp;
    logic [NUM_AXES-1:0][RATE_WIDTH-1:0] want_vec;
    logic [NUM_AXES-1:0][RATE_WIDTH-1:0] gyro_vec;
    logic [NUM_AXES-1:0]               lane_done;
    lane_req_t                         lane_req [NUM_AXES];
    lane_rsp_t                         lane_rsp [NUM_AXES];

    tpid_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign accept = req.valid & ready_int;

    always_comb
    begin
        priority if (req.step_us < STEP_MIN_US)
            dt_clamp = DT_W'(STEP_MIN_US);
        else if (req.step_us > STEP_MAX_US)
            dt_clamp = DT_W'(STEP_MAX_US);
        else
            dt_clamp = req.step_us[DT_W-1:0];
    end

    assign want_vec[AX_ROLL]  = req.want_roll;
    assign want_vec[AX_PITCH] = req.want_pitch;
    assign want_vec[AX_YAW]   = req.want_yaw;
    assign gyro_vec[AX_ROLL]  = req.gyro_roll;
    assign gyro_vec[AX_PITCH] = req.gyro_pitch;
    assign gyro_vec[AX_YAW]   = req.gyro_yaw;

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_lane
        assign lane_req[a] = '{start:             accept,
                               clear:             req.command,
                               dt:                dt_clamp,
                               want:              want_vec[a],
                               gyro:              gyro_vec[a],
                               gains:             cfg.gains[a],
                               command_limit:     cfg.command_limit,
                               accumulator_limit: cfg.accumulator_limit};

        tpid_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .req   (lane_req[a]),
            .rsp   (lane_rsp[a])
        );

        assign lane_done[a] = lane_rsp[a].done;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_BUSY;
            ST_BUSY: if (load) state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ready_int = (state_reg == ST_IDLE);
        all_done  = &(done_bits_reg | lane_done);
        load      = (state_reg == ST_BUSY) && all_done && (!rsp_valid_reg || rsp.ready);
    end

    // merge: collect lane finishes, then move all three drives into the output word
    always_comb
    begin
        done_bits_next = load ? '0 : (done_bits_reg | lane_done);
        drive_next     = drive_reg;
        rsp_valid_next = rsp_valid_reg;
        if (load)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                drive_next[a] = lane_rsp[a].drive;
            end
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            done_bits_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            done_bits_reg <= done_bits_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        drive_reg <= drive_next;
    end

    assign req.ready       = ready_int;
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.roll_drive  = drive_reg[AX_ROLL];
    assign rsp.pitch_drive = drive_reg[AX_PITCH];
    assign rsp.yaw_drive   = drive_reg[AX_YAW];

`ifndef NO_ASSERTIONS
    a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        (lane_done == '0) || (lane_done == '1))
        else $error("lanes finished out of step");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req.ready)
        else $error("word taken while lanes busy");

    a_clear_finishes_next: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.command) |=> (lane_done == '1))
        else $error("clear word did not finish in one cycle");

    a_run_not_early: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !req.command) |=> (lane_done == '0))
        else $error("run word finished too early");
`endif

endmodule
